FILE: rtl/sbsh_pkg.sv
// ---------------------------------------------------------------------------
// sbsh_pkg: shared types, constants and functions for the byte stream hasher
// round constants, initial hash value and the sigma functions of the standard
// ---------------------------------------------------------------------------
package sbsh_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [7:0][31:0] work_t;

  localparam int unsigned CountW   = 61;
  localparam logic [3:0]  LenHiAddr = 4'd14;
  localparam logic [3:0]  LenLoAddr = 4'd15;

  typedef logic [CountW-1:0] count_t;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // word 0 sits at index 0, so the list runs from word 7 down
  localparam work_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

FILE: rtl/sbsh_round.sv
// ---------------------------------------------------------------------------
// sbsh_round: one compression round
// updates the eight working variables from one schedule word and one constant
// ---------------------------------------------------------------------------
module sbsh_round (
  input  sbsh_pkg::work_t v,
  input  sbsh_pkg::word_t w,
  input  sbsh_pkg::word_t k,
  output sbsh_pkg::work_t v_next
);

  sbsh_pkg::word_t choose;
  sbsh_pkg::word_t major;
  sbsh_pkg::word_t t1;
  sbsh_pkg::word_t t2;

  always_comb begin
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1     = v[7] + sbsh_pkg::big_sigma1(v[4]) + choose + k + w;
    t2     = sbsh_pkg::big_sigma0(v[0]) + major;
    v_next[0] = t1 + t2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + t1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];
  end

endmodule

FILE: rtl/sha256_byte_stream_hasher.sv
// ---------------------------------------------------------------------------
// sha256_byte_stream_hasher: byte stream in, digest words out
// message bytes are packed into a 16-word block memory and compressed
// ---------------------------------------------------------------------------
// usage
//   msg channel: one transaction per byte (byte_present) and/or end of message
//   (final_item). msg_stall is high whenever the block is busy or in reset.
//   dig channel: eight transactions per message, word 0 first, last_word on 7.
// timing
//   a byte that does not complete a block does not stall the channel.
//   the 64th byte of a block starts a compression: load, 64 rounds at one
//   per cycle and a chaining add, all on the single round unit.
//   a final transaction takes a pad write, a zero sweep of up to 13 writes at
//   one word per cycle plus a closing step, 2 length writes and a
//   compression; a tail of 56 bytes or more first costs a short sweep, an
//   extra compression and a second sweep of 14 writes.
//   digest words then leave one per cycle while dig_stall is low.
// reset
//   chaining value returns to the initial hash, byte counts clear; block
//   memory contents are left as they are. when dig_stall is high the current
//   word holds and nothing else moves until it is taken.
// ---------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        final_item,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PAD, ST_ZERO, ST_LEN_HI, ST_LEN_LO,
    ST_PREP, ST_ROUND, ST_ADD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {NX_IDLE, NX_PAD, NX_ZERO, NX_OUT} after_t;

  state_t                       state;
  after_t                       nxt;
  sbsh_pkg::work_t              hash;
  sbsh_pkg::work_t              v;
  sbsh_pkg::work_t              v_rnd;
  sbsh_pkg::word_t              win [16];
  sbsh_pkg::word_t              w_pre;
  sbsh_pkg::word_t              w_sched;
  sbsh_pkg::word_t              cur_w;
  logic [5:0]                   rnd;
  logic [5:0]                   fill;
  logic [31:0]                  acc;
  logic [31:0]                  byte_word;
  logic [31:0]                  pad_word;
  sbsh_pkg::count_t             byte_count;
  logic [63:0]                  bit_len;
  logic [4:0]                   zero_addr;
  logic [4:0]                   zero_lim;
  logic                         two_blk;
  logic [2:0]                   out_idx;

  logic [31:0] buf_mem [16];
  logic [31:0] mem_rd;
  logic [3:0]  rd_addr;
  logic        mem_we;
  logic [3:0]  mem_wa;
  logic [31:0] mem_wd;

  logic msg_accept;
  logic dig_accept;

  assign msg_stall  = rst | (state != ST_IDLE);
  assign msg_accept = msg_valid & ~msg_stall;
  assign dig_valid  = (state == ST_OUT);
  assign dig_accept = dig_valid & ~dig_stall;

  assign digest_word = hash[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  assign bit_len  = {byte_count, 3'b000};
  assign zero_lim = two_blk ? 5'd16 : 5'd14;

  // lane 0 is the most significant byte of a block word
  always_comb begin
    byte_word = acc;
    unique case (fill[1:0])
      2'd0: byte_word[31:24] = data_byte;
      2'd1: byte_word[23:16] = data_byte;
      2'd2: byte_word[15:8]  = data_byte;
      2'd3: byte_word[7:0]   = data_byte;
    endcase
  end

  // bytes already held, then the 0x80 marker, then zeros
  always_comb begin
    pad_word = '0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < fill[1:0]) begin
        pad_word[31-8*i -: 8] = acc[31-8*i -: 8];
      end else if (2'(i) == fill[1:0]) begin
        pad_word[31-8*i -: 8] = 8'h80;
      end
    end
  end

  // schedule word for the next round, from the 16-word window
  assign w_sched = win[1] + sbsh_pkg::small_sigma0(win[2]) + win[10]
                 + sbsh_pkg::small_sigma1(win[15]);
  assign cur_w   = (rnd[5:4] == 2'b00) ? mem_rd : w_pre;

  sbsh_round u_round (
    .v      (v),
    .w      (cur_w),
    .k      (sbsh_pkg::RoundK[rnd]),
    .v_next (v_rnd)
  );

  // read one word ahead of the round that uses it
  assign rd_addr = (state == ST_ROUND) ? (rnd[3:0] + 4'd1) : 4'd0;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = fill[5:2];
    mem_wd = byte_word;
    unique case (state)
      ST_IDLE: begin
        mem_we = msg_accept & byte_present & (fill[1:0] == 2'd3);
      end
      ST_PAD: begin
        mem_we = 1'b1;
        mem_wd = pad_word;
      end
      ST_ZERO: begin
        mem_we = (zero_addr < zero_lim);
        mem_wa = zero_addr[3:0];
        mem_wd = '0;
      end
      ST_LEN_HI: begin
        mem_we = 1'b1;
        mem_wa = sbsh_pkg::LenHiAddr;
        mem_wd = bit_len[63:32];
      end
      ST_LEN_LO: begin
        mem_we = 1'b1;
        mem_wa = sbsh_pkg::LenLoAddr;
        mem_wd = bit_len[31:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[mem_wa] <= mem_wd;
    end
    mem_rd <= buf_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      nxt        <= NX_IDLE;
      hash       <= sbsh_pkg::HashInit;
      fill       <= '0;
      byte_count <= '0;
      out_idx    <= '0;
      rnd        <= '0;
      two_blk    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (msg_accept) begin
            if (byte_present) begin
              acc        <= byte_word;
              fill       <= fill + 6'd1;
              byte_count <= byte_count + sbsh_pkg::count_t'(1);
            end
            if (byte_present && fill == 6'd63) begin
              state <= ST_PREP;
              nxt   <= final_item ? NX_PAD : NX_IDLE;
            end else if (final_item) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          zero_addr <= {1'b0, fill[5:2]} + 5'd1;
          two_blk   <= (fill >= 6'd56);
          state     <= ST_ZERO;
        end
        ST_ZERO: begin
          if (zero_addr < zero_lim) begin
            zero_addr <= zero_addr + 5'd1;
          end else if (two_blk) begin
            state <= ST_PREP;
            nxt   <= NX_ZERO;
          end else begin
            state <= ST_LEN_HI;
          end
        end
        ST_LEN_HI: begin
          state <= ST_LEN_LO;
        end
        ST_LEN_LO: begin
          state <= ST_PREP;
          nxt   <= NX_OUT;
        end
        ST_PREP: begin
          v     <= hash;
          rnd   <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          v <= v_rnd;
          for (int i = 0; i < 15; i++) begin
            win[i] <= win[i+1];
          end
          win[15] <= cur_w;
          w_pre   <= w_sched;
          rnd     <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + v[i];
          end
          unique case (nxt)
            NX_IDLE: state <= ST_IDLE;
            NX_PAD:  state <= ST_PAD;
            NX_ZERO: begin
              zero_addr <= '0;
              two_blk   <= 1'b0;
              state     <= ST_ZERO;
            end
            NX_OUT: begin
              out_idx <= '0;
              state   <= ST_OUT;
            end
          endcase
        end
        ST_OUT: begin
          if (dig_accept) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              hash       <= sbsh_pkg::HashInit;
              fill       <= '0;
              byte_count <= '0;
              state      <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // the last digest transaction leaves the block ready for a new message
  a_restart: assert property (@(posedge clk) disable iff (rst)
    dig_accept && last_word |=> (hash == sbsh_pkg::HashInit) && (state == ST_IDLE))
    else $error("chaining value not restored after digest");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    dig_accept && !last_word |=> dig_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest words out of order");

  // the block memory must not change under a running compression
  a_no_write_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND || state == ST_PREP) |-> !mem_we)
    else $error("block memory written during compression");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) && (rnd == 6'd63) |=> (state == ST_ADD))
    else $error("compression did not end after the last round");

endmodule
